// File: hdl/gnno_pkg.sv
// Shared constants and types for the greedy nearest-neighbor order unit.
package gnno_pkg;

   localparam int MAX_ITEMS_DEF = 64;

   localparam int FIELD_W   = 6;
   localparam int COST_W    = 32;
   localparam int TOTAL_W   = 39;
   localparam int CSR_W     = 7;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_W-1:0] ITEM_COUNT_RST  = 7'd64;
   localparam logic [CSR_W-1:0] START_COUNT_RST = 7'd20;

   localparam logic [CSR_IDX_W-1:0] CSR_ITEM_COUNT  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_COUNT = 1'd1;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_RUN  = 1'b1;

   localparam logic signed [TOTAL_W-1:0] TOTAL_MAXPOS = {1'b0, {(TOTAL_W-1){1'b1}}};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_SCAN,
      ST_DRAIN,
      ST_STEP,
      ST_FINISH,
      ST_EMIT_RD,
      ST_EMIT_LD
   } gnno_state_type;

endpackage

// File: hdl/greedy_nearest_neighbor_order_unit.sv
// Greedy nearest-neighbor path builder: cost matrix memory, search sequencer, path output.
//
// Load commands write one signed cost entry into the cost memory; entries whose row or
// column is not below MAX_ITEMS are dropped. A run command tries S start items
// (start_count, 0 read as 1, clipped to n = item_count clamped to 1..MAX_ITEMS),
// building each path greedily by scanning one row of the cost memory per appended
// item, one entry per cycle through its single read port. After the search the best
// path is emitted as n results, one at a time, while the result channel is not
// stalled. The block takes no new item from the end of a run command until its last
// result has been moved into the output register. The cost memory is not cleared; only
// entries that have been loaded may be used by a run. Both path buffers and the result
// register need no clearing pass.
module greedy_nearest_neighbor_order_unit #(
   parameter int MAX_ITEMS = gnno_pkg::MAX_ITEMS_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  logic                                      req_command,
   input  logic [gnno_pkg::FIELD_W-1:0]              req_row_item,
   input  logic [gnno_pkg::FIELD_W-1:0]              req_col_item,
   input  logic signed [gnno_pkg::COST_W-1:0]        req_cost_value,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic [gnno_pkg::FIELD_W-1:0]              rsp_position,
   output logic [gnno_pkg::FIELD_W-1:0]              rsp_item_index,
   output logic signed [gnno_pkg::TOTAL_W-1:0]       rsp_path_total,
   output logic                                      rsp_last_flag,
   input  logic                                      csr_we,
   input  logic [gnno_pkg::CSR_IDX_W-1:0]            csr_index,
   input  logic [gnno_pkg::CSR_W-1:0]                csr_wdata
);
   import gnno_pkg::*;

   localparam int IW    = $clog2(MAX_ITEMS);
   localparam int CW    = $clog2(MAX_ITEMS + 1);
   localparam int DEPTH = MAX_ITEMS * MAX_ITEMS;
   localparam int AW    = $clog2(DEPTH);

   gnno_state_type state_ff, state_in;

   logic [CSR_W-1:0]  item_count_ff, start_count_ff;
   logic [CW-1:0]     n_ff, n_in, s_ff, s_in;
   logic [IW-1:0]     start_ff, start_in;
   logic [IW-1:0]     len_ff, len_in;
   logic [IW-1:0]     last_ff, last_in;
   logic [IW-1:0]     k_ff, k_in;
   logic [IW-1:0]     rd_k_ff;
   logic              rd_vld_ff;
   logic [IW-1:0]     pos_ff, pos_in;
   logic [MAX_ITEMS-1:0] used_ff, used_in;
   logic              found_ff, found_in;
   logic signed [COST_W-1:0]  low_ff, low_in;
   logic [IW-1:0]     pick_ff, pick_in;
   logic signed [TOTAL_W-1:0] total_ff, total_in;
   logic signed [TOTAL_W-1:0] best_total_ff, best_total_in;
   logic              tsel_ff, tsel_in, best_sel_ff, best_sel_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [FIELD_W-1:0] rsp_position_ff, rsp_position_in;
   logic [FIELD_W-1:0] rsp_item_index_ff, rsp_item_index_in;
   logic signed [TOTAL_W-1:0] rsp_path_total_ff, rsp_path_total_in;
   logic              rsp_last_flag_ff, rsp_last_flag_in;

   logic signed [COST_W-1:0] cost_mem [DEPTH];
   logic signed [COST_W-1:0] cost_rd_ff;
   logic              cost_we, cost_re;
   logic [AW-1:0]     cost_waddr, cost_raddr;

   logic [IW-1:0]     path_mem [2][MAX_ITEMS];
   logic [IW-1:0]     path_rd_ff;
   logic              path_we, path_re;
   logic [IW-1:0]     path_waddr, path_wdata;

   logic              req_fire, load_ok, take, out_free, last_step, last_start, last_pos;
   logic [CW-1:0]     n_calc;
   logic [CSR_W-1:0]  s_raw;

   assign req_fire   = req_valid && req_ready;
   assign load_ok    = ({1'b0, req_row_item} < 7'(MAX_ITEMS)) &&
                       ({1'b0, req_col_item} < 7'(MAX_ITEMS));
   assign take       = rd_vld_ff && !used_ff[rd_k_ff] && (!found_ff || (cost_rd_ff < low_ff));
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign last_step  = (CW'(len_ff) + CW'(1)) == n_ff;
   assign last_start = (CW'(start_ff) + CW'(1)) == s_ff;
   assign last_pos   = (CW'(pos_ff) + CW'(1)) == n_ff;

   assign cost_waddr = AW'(AW'(req_row_item[IW-1:0]) * AW'(MAX_ITEMS) +
                           AW'(req_col_item[IW-1:0]));
   assign cost_raddr = AW'(AW'(last_ff) * AW'(MAX_ITEMS) + AW'(k_ff));

   // clamp the configured counts for a run
   always_comb begin
      if (item_count_ff == '0) begin
         n_calc = CW'(1);
      end else if (item_count_ff > 7'(MAX_ITEMS)) begin
         n_calc = CW'(MAX_ITEMS);
      end else begin
         n_calc = CW'(item_count_ff);
      end
      s_raw = (start_count_ff == '0) ? 7'd1 : start_count_ff;
      if (s_raw > 7'(n_calc)) begin
         s_raw = 7'(n_calc);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_command == CMD_RUN) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            state_in = (n_ff == CW'(1)) ? ST_FINISH : ST_SCAN;
         end
         ST_SCAN: begin
            if ((CW'(k_ff) + CW'(1)) == n_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_STEP;
         end
         ST_STEP: begin
            state_in = last_step ? ST_FINISH : ST_SCAN;
         end
         ST_FINISH: begin
            state_in = last_start ? ST_EMIT_RD : ST_START;
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_LD;
         end
         ST_EMIT_LD: begin
            if (out_free) begin
               state_in = last_pos ? ST_IDLE : ST_EMIT_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs and datapath next values
   always_comb begin
      req_ready         = 1'b0;
      cost_we           = 1'b0;
      cost_re           = 1'b0;
      path_we           = 1'b0;
      path_re           = 1'b0;
      path_waddr        = len_ff;
      path_wdata        = pick_ff;
      n_in              = n_ff;
      s_in              = s_ff;
      start_in          = start_ff;
      len_in            = len_ff;
      last_in           = last_ff;
      k_in              = k_ff;
      pos_in            = pos_ff;
      used_in           = used_ff;
      found_in          = found_ff;
      low_in            = low_ff;
      pick_in           = pick_ff;
      total_in          = total_ff;
      best_total_in     = best_total_ff;
      tsel_in           = tsel_ff;
      best_sel_in       = best_sel_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_position_in   = rsp_position_ff;
      rsp_item_index_in = rsp_item_index_ff;
      rsp_path_total_in = rsp_path_total_ff;
      rsp_last_flag_in  = rsp_last_flag_ff;

      // fold in the entry read in the previous cycle
      if (take) begin
         found_in = 1'b1;
         low_in   = cost_rd_ff;
         pick_in  = rd_k_ff;
      end

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_fire && req_command == CMD_LOAD) begin
               cost_we = load_ok;
            end
            if (req_fire && req_command == CMD_RUN) begin
               n_in          = n_calc;
               s_in          = CW'(s_raw);
               start_in      = '0;
               best_total_in = TOTAL_MAXPOS;
            end
         end
         ST_START: begin
            used_in           = '0;
            used_in[start_ff] = 1'b1;
            path_we           = 1'b1;
            path_waddr        = '0;
            path_wdata        = start_ff;
            last_in           = start_ff;
            len_in            = IW'(1);
            total_in          = '0;
            found_in          = 1'b0;
            k_in              = '0;
         end
         ST_SCAN: begin
            cost_re = 1'b1;
            k_in    = k_ff + IW'(1);
         end
         ST_DRAIN: begin
            k_in = '0;
         end
         ST_STEP: begin
            path_we          = 1'b1;
            path_waddr       = len_ff;
            path_wdata       = pick_ff;
            used_in[pick_ff] = 1'b1;
            last_in          = pick_ff;
            total_in         = total_ff + TOTAL_W'(low_ff);
            found_in         = 1'b0;
            k_in             = '0;
            if (!last_step) begin
               len_in = len_ff + IW'(1);
            end
         end
         ST_FINISH: begin
            if (total_ff < best_total_ff) begin
               best_total_in = total_ff;
               best_sel_in   = tsel_ff;
               tsel_in       = !tsel_ff;
            end
            if (last_start) begin
               pos_in = '0;
            end else begin
               start_in = start_ff + IW'(1);
            end
         end
         ST_EMIT_RD: begin
            path_re = 1'b1;
         end
         ST_EMIT_LD: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_position_in   = FIELD_W'(pos_ff);
               rsp_item_index_in = FIELD_W'(path_rd_ff);
               rsp_path_total_in = best_total_ff;
               rsp_last_flag_in  = last_pos;
               pos_in            = pos_ff + IW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         item_count_ff  <= ITEM_COUNT_RST;
         start_count_ff <= START_COUNT_RST;
         rd_vld_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         tsel_ff        <= 1'b0;
         best_sel_ff    <= 1'b0;
         used_ff        <= '0;
         found_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_vld_ff    <= cost_re;
         rsp_valid_ff <= rsp_valid_in;
         tsel_ff      <= tsel_in;
         best_sel_ff  <= best_sel_in;
         used_ff      <= used_in;
         found_ff     <= found_in;
         if (csr_we) begin
            case (csr_index)
               CSR_ITEM_COUNT:  item_count_ff  <= csr_wdata;
               CSR_START_COUNT: start_count_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff              <= n_in;
      s_ff              <= s_in;
      start_ff          <= start_in;
      len_ff            <= len_in;
      last_ff           <= last_in;
      k_ff              <= k_in;
      rd_k_ff           <= k_ff;
      pos_ff            <= pos_in;
      low_ff            <= low_in;
      pick_ff           <= pick_in;
      total_ff          <= total_in;
      best_total_ff     <= best_total_in;
      rsp_position_ff   <= rsp_position_in;
      rsp_item_index_ff <= rsp_item_index_in;
      rsp_path_total_ff <= rsp_path_total_in;
      rsp_last_flag_ff  <= rsp_last_flag_in;
   end

   always_ff @(posedge clock) begin
      if (cost_we) begin
         cost_mem[cost_waddr] <= req_cost_value;
      end
   end

   always_ff @(posedge clock) begin
      if (cost_re) begin
         cost_rd_ff <= cost_mem[cost_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (path_we) begin
         path_mem[tsel_ff][path_waddr] <= path_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (path_re) begin
         path_rd_ff <= path_mem[best_sel_ff][pos_ff];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_position   = rsp_position_ff;
   assign rsp_item_index = rsp_item_index_ff;
   assign rsp_path_total = rsp_path_total_ff;
   assign rsp_last_flag  = rsp_last_flag_ff;

endmodule
